### hdl/asp_pkg.sv
// Shared types and constants for the aligned slot packer.
// No dependencies; imported by every module of the block.
package asp_pkg;

    // Fixed sizes of the packer
    localparam int ALIGN      = 4096;   // slot alignment, a power of two
    localparam int MAX_SLOTS  = 256;    // slots per manifest, at most 256
    localparam int MAX_CHUNKS = 64;     // chunks per split embedding

    localparam int BYTE_W = 48;
    localparam int ROW_W  = 32;
    localparam int SLOT_W = 8;
    localparam int ROLE_W = 2;
    localparam int FP_W   = BYTE_W + 1;                        // aligned value, carry bit
    localparam int LIM_W  = BYTE_W + $clog2(MAX_CHUNKS + 1);   // rows-per-chunk * max chunks

    // Buffer roles
    localparam logic [ROLE_W-1:0] ROLE_EMB   = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_POSID = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_EXTRA = 2'd2;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOT_SPLIT,
        ST_ROW_BIG,
        ST_POSID_BIG,
        ST_EXTRA_BIG,
        ST_OVERFLOW
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_RB,
        S_WAIT_RB,
        S_CHK_RB,
        S_WAIT_RPC,
        S_CHK_N,
        S_LEN,
        S_MUL_LO,
        S_MUL_HI,
        S_ALIGN,
        S_PLACE,
        S_ERR
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    div_sel_rpc;
        logic    latch_rb;
        logic    latch_rpc;
        logic    calc_len;
        logic    mul_lo;
        logic    mul_hi;
        logic    calc_align;
        logic    place;
        logic    emit_err;
        t_status err_code;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic    last;
        logic    split;
        logic    rows_zero;
        logic    single_err;
        t_status single_code;
        logic    fp_wide;
        logic    div_busy;
        logic    rb_bad;
        logic    chunks_over;
        logic    place_fail;
        logic    chunk_final;
        logic    out_free;
    } t_dp_stat;

endpackage

### hdl/aligned_slot_packer.sv
// Top level of the aligned slot packer.
// Depends on asp_pkg, asp_ctrl, asp_datapath (which holds asp_div).
//
// Buffer descriptors arrive one transaction at a time on s_axis; each one's
// byte count is rounded up to a multiple of 4096 bytes and packed next-fit into
// slots of at most the configured size (zero: no limit). An embedding bigger
// than the limit is split into row chunks, one result per chunk; anything
// else gives one result. Errors give a single error result with done set and
// abort the manifest: inputs up to and including the next tlast are dropped
// without results, and results already sent for that manifest are to be
// discarded downstream. One descriptor is in work at a time. A buffer that is
// not split goes through a decode state and then a place state, which writes
// its result into the output register. A split embedding runs two divisions
// on the shared one-bit-per-cycle divider (bytes per row, rows per chunk)
// with a check after each, then per chunk the steps length, two-step 32x24
// multiply, align and place; a chunk waits in place while the output
// register is still full. The next descriptor is taken once the last result
// is in the output register, even if m_axis has not taken it yet. Write the
// limit register only while the block is idle.
module aligned_slot_packer
    import asp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,

    // limit register
    input  logic          i_cfg_we,
    input  logic [47:0]   i_cfg_wdata,        // largest slot size, zero for no limit

    // descriptor stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [79:0]   s_axis_tdata,       // byte_count[47:0], row_count[79:48]
    input  logic [1:0]    s_axis_tuser,       // command[1:0]
    input  logic          s_axis_tlast,       // last_item

    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,       // slot_index[7:0], first_row[39:8],
                                              // row_len[71:40], footprint[119:72]
    output logic [5:0]    m_axis_tuser,       // role[1:0], status[4:2], manifest_done[5]
    output logic          m_axis_tlast        // run_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic [SLOT_W-1:0] out_slot;
    logic [ROLE_W-1:0] out_role;
    logic [ROW_W-1:0]  out_first;
    logic [ROW_W-1:0]  out_len;
    logic [BYTE_W-1:0] out_fp;
    t_status           out_status;
    logic              out_done;

    // controller: accepts a descriptor only when idle
    asp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    asp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_in    (s_axis_tuser),
        .i_bytes     (s_axis_tdata[47:0]),
        .i_rows      (s_axis_tdata[79:48]),
        .i_last      (s_axis_tlast),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_slot      (out_slot),
        .o_role      (out_role),
        .o_first     (out_first),
        .o_len       (out_len),
        .o_fp        (out_fp),
        .o_status    (out_status),
        .o_run_last  (m_axis_tlast),
        .o_done      (out_done)
    );

    assign m_axis_tdata = {out_fp, out_len, out_first, out_slot};
    assign m_axis_tuser = {out_done, out_status, out_role};

endmodule

### hdl/asp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on asp_pkg.
module asp_div
    import asp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BYTE_W-1:0] i_dividend,
    input  logic [BYTE_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [BYTE_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(BYTE_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_rem;
    logic [BYTE_W-1:0] r_quo;     // dividend bits shift out, quotient bits shift in
    logic [BYTE_W-1:0] r_dvs;

    logic [BYTE_W:0]   rem_sh;
    logic [BYTE_W+1:0] diff;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[BYTE_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign ge     = ~diff[BYTE_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(BYTE_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[BYTE_W-1:0] : rem_sh[BYTE_W-1:0];
            r_quo <= {r_quo[BYTE_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

### hdl/asp_datapath.sv
// Datapath of the slot packer: input capture, limit register, divider, chunk
// arithmetic, next-fit packing state and the output register. Depends on asp_pkg, asp_div.
module asp_datapath
    import asp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    input  logic [1:0]           i_cmd_in,
    input  logic [BYTE_W-1:0]    i_bytes,
    input  logic [ROW_W-1:0]     i_rows,
    input  logic                 i_last,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [ROLE_W-1:0]    o_role,
    output logic [ROW_W-1:0]     o_first,
    output logic [ROW_W-1:0]     o_len,
    output logic [BYTE_W-1:0]    o_fp,
    output t_status              o_status,
    output logic                 o_run_last,
    output logic                 o_done
);

    localparam int HALF = BYTE_W / 2;
    localparam logic [FP_W-1:0] ALIGN_M1 = FP_W'(ALIGN - 1);

    function automatic logic [FP_W-1:0] align_up(input logic [BYTE_W-1:0] x);
        align_up = ({1'b0, x} + ALIGN_M1) & ~ALIGN_M1;
    endfunction

    // config and captured descriptor
    logic [BYTE_W-1:0] r_max;
    logic [ROLE_W-1:0] r_role;
    logic [BYTE_W-1:0] r_bytes;
    logic [ROW_W-1:0]  r_rows;
    logic              r_last;
    logic [FP_W-1:0]   r_fp;

    // chunk arithmetic
    logic [BYTE_W-1:0]       r_rb;
    logic [BYTE_W-1:0]       r_rpc;
    logic [LIM_W-1:0]        r_lim;
    logic [ROW_W-1:0]        r_start;
    logic [ROW_W-1:0]        r_len;
    logic [ROW_W+HALF-1:0]   r_pp;
    logic [BYTE_W-1:0]       r_cbytes;
    logic [FP_W-1:0]         r_cfp;

    // packing state
    logic [BYTE_W-1:0] r_group;
    logic [SLOT_W-1:0] r_slot;
    logic              r_empty;

    // output register
    logic              r_ovalid;
    logic [SLOT_W-1:0] r_oslot;
    logic [ROLE_W-1:0] r_orole;
    logic [ROW_W-1:0]  r_ofirst;
    logic [ROW_W-1:0]  r_olen;
    logic [BYTE_W-1:0] r_ofp;
    t_status           r_ostat;
    logic              r_olast;
    logic              r_odone;

    logic              limited, fp_over, split;
    logic              div_busy;
    logic [BYTE_W-1:0] div_q, div_a, div_b, maxa, rpc_c;
    logic [ROW_W-1:0]  rem_rows, len_c;
    logic [ROW_W+HALF-1:0] hi_pp;
    logic [FP_W-1:0]   fpx;
    logic [FP_W:0]     sum1, sum2;
    logic              over, slot_full, wide, chunk_final, out_free;
    logic [SLOT_W:0]   slot_inc;
    logic [BYTE_W-1:0] n_group;
    logic [SLOT_W-1:0] n_slot;

    assign limited = r_max != '0;
    assign fp_over = r_fp > {1'b0, r_max};
    assign split   = (r_role == ROLE_EMB) && limited && fp_over;
    assign maxa    = r_max & ~ALIGN_M1[BYTE_W-1:0];

    // shared divider: bytes / rows, then aligned limit / bytes per row
    assign div_a = i_cmd.div_sel_rpc ? maxa : r_bytes;
    assign div_b = i_cmd.div_sel_rpc ? r_rb : {{(BYTE_W-ROW_W){1'b0}}, r_rows};

    asp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign rpc_c    = (div_q == '0) ? BYTE_W'(1) : div_q;
    assign rem_rows = r_rows - r_start;
    assign len_c    = ({{(BYTE_W-ROW_W){1'b0}}, rem_rows} < r_rpc) ? rem_rows
                                                                    : r_rpc[ROW_W-1:0];
    assign hi_pp    = r_len * r_rb[BYTE_W-1:HALF];

    // next-fit placement
    assign fpx       = split ? r_cfp : r_fp;
    assign sum1      = {2'b00, r_group} + {1'b0, fpx};
    assign over      = !r_empty && limited && (sum1 > {2'b00, r_max});
    assign slot_inc  = {1'b0, r_slot} + 1'b1;
    assign slot_full = over && (slot_inc >= (SLOT_W+1)'(MAX_SLOTS));
    assign sum2      = over ? {1'b0, fpx} : sum1;
    assign wide      = sum2[FP_W:BYTE_W] != '0;
    assign n_group   = sum2[BYTE_W-1:0];
    assign n_slot    = over ? slot_inc[SLOT_W-1:0] : r_slot;
    assign chunk_final = !split ||
                         (({1'b0, r_start} + {1'b0, r_len}) >= {1'b0, r_rows});
    assign out_free  = !r_ovalid || i_out_ready;

    assign o_stat.last        = r_last;
    assign o_stat.split       = split;
    assign o_stat.rows_zero   = r_rows == '0;
    assign o_stat.single_err  = (r_role != ROLE_EMB) && limited && fp_over;
    assign o_stat.single_code = (r_role == ROLE_POSID) ? ST_POSID_BIG : ST_EXTRA_BIG;
    assign o_stat.fp_wide     = r_fp[BYTE_W];
    assign o_stat.div_busy    = div_busy;
    assign o_stat.rb_bad      = (r_rb == '0) || (align_up(r_rb) > {1'b0, r_max});
    assign o_stat.chunks_over = {{(LIM_W-ROW_W){1'b0}}, r_rows} > r_lim;
    assign o_stat.place_fail  = slot_full || wide;
    assign o_stat.chunk_final = chunk_final;
    assign o_stat.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_role  <= (i_cmd_in == ROLE_EMB || i_cmd_in == ROLE_POSID) ? i_cmd_in
                                                                       : ROLE_EXTRA;
            r_bytes <= i_bytes;
            r_rows  <= i_rows;
            r_last  <= i_last;
            r_fp    <= align_up(i_bytes);
        end
        if (i_cmd.latch_rb) begin
            r_rb <= div_q;
        end
        if (i_cmd.latch_rpc) begin
            r_rpc   <= rpc_c;
            r_lim   <= LIM_W'(rpc_c) * LIM_W'(MAX_CHUNKS);
            r_start <= '0;
        end
        if (i_cmd.calc_len) begin
            r_len <= len_c;
        end
        if (i_cmd.mul_lo) begin
            r_pp <= r_len * r_rb[HALF-1:0];
        end
        if (i_cmd.mul_hi) begin
            // product is at most byte_count, so the low BYTE_W bits are exact
            r_cbytes <= r_pp[BYTE_W-1:0] + {hi_pp[HALF-1:0], {HALF{1'b0}}};
        end
        if (i_cmd.calc_align) begin
            r_cfp <= align_up(r_cbytes);
        end
        if (i_cmd.place) begin
            r_start <= r_start + r_len;
        end
    end

    // packing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_slot  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.emit_err || (i_cmd.place && chunk_final && r_last)) begin
            r_group <= '0;
            r_slot  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.place) begin
            r_group <= n_group;
            r_slot  <= n_slot;
            r_empty <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.place || i_cmd.emit_err) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_oslot  <= '0;
            r_orole  <= r_role;
            r_ofirst <= '0;
            r_olen   <= '0;
            r_ofp    <= '0;
            r_ostat  <= i_cmd.err_code;
            r_olast  <= 1'b1;
            r_odone  <= 1'b1;
        end else if (i_cmd.place) begin
            r_oslot  <= n_slot;
            r_orole  <= r_role;
            r_ofirst <= split ? r_start : '0;
            r_olen   <= split ? r_len : r_rows;
            r_ofp    <= fpx[BYTE_W-1:0];
            r_ostat  <= ST_OK;
            r_olast  <= chunk_final;
            r_odone  <= chunk_final && r_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_slot      = r_oslot;
    assign o_role      = r_orole;
    assign o_first     = r_ofirst;
    assign o_len       = r_olen;
    assign o_fp        = r_ofp;
    assign o_status    = r_ostat;
    assign o_run_last  = r_olast;
    assign o_done      = r_odone;

endmodule

### hdl/asp_ctrl.sv
// Sequencing state machine of the slot packer; drives asp_datapath by commands.
// Depends on asp_pkg.
module asp_ctrl
    import asp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_status r_err, n_err;
    logic    r_aborted, n_aborted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_err     <= ST_OK;
            r_aborted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_err     <= n_err;
            r_aborted <= n_aborted;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_err     = r_err;
        n_aborted = r_aborted;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_aborted) begin
                    n_aborted = !i_stat.last;
                    n_state   = S_IDLE;
                end else if (i_stat.split) begin
                    if (i_stat.rows_zero) begin
                        n_err   = ST_NOT_SPLIT;
                        n_state = S_ERR;
                    end else begin
                        n_state = S_DIV_RB;
                    end
                end else if (i_stat.single_err) begin
                    n_err   = i_stat.single_code;
                    n_state = S_ERR;
                end else if (i_stat.fp_wide) begin
                    n_err   = ST_OVERFLOW;
                    n_state = S_ERR;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DIV_RB:   n_state = S_WAIT_RB;
            S_WAIT_RB: begin
                if (!i_stat.div_busy) begin
                    n_state = S_CHK_RB;
                end
            end
            S_CHK_RB: begin
                if (i_stat.rb_bad) begin
                    n_err   = ST_ROW_BIG;
                    n_state = S_ERR;
                end else begin
                    n_state = S_WAIT_RPC;
                end
            end
            S_WAIT_RPC: begin
                if (!i_stat.div_busy) begin
                    n_state = S_CHK_N;
                end
            end
            S_CHK_N: begin
                if (i_stat.chunks_over) begin
                    n_err   = ST_OVERFLOW;
                    n_state = S_ERR;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN:    n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_ALIGN;
            S_ALIGN:  n_state = S_PLACE;
            S_PLACE: begin
                if (i_stat.out_free) begin
                    if (i_stat.place_fail) begin
                        n_err   = ST_OVERFLOW;
                        n_state = S_ERR;
                    end else if (i_stat.chunk_final) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_LEN;
                    end
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    n_aborted = !i_stat.last;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.err_code = r_err;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV_RB:   o_cmd.div_start = 1'b1;
            S_WAIT_RB:  o_cmd.latch_rb  = !i_stat.div_busy;
            S_CHK_RB: begin
                o_cmd.div_sel_rpc = 1'b1;
                o_cmd.div_start   = !i_stat.rb_bad;
            end
            S_WAIT_RPC: o_cmd.latch_rpc  = !i_stat.div_busy;
            S_LEN:      o_cmd.calc_len   = 1'b1;
            S_MUL_LO:   o_cmd.mul_lo     = 1'b1;
            S_MUL_HI:   o_cmd.mul_hi     = 1'b1;
            S_ALIGN:    o_cmd.calc_align = 1'b1;
            S_PLACE:    o_cmd.place      = i_stat.out_free && !i_stat.place_fail;
            S_ERR:      o_cmd.emit_err   = i_stat.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for aligned_slot_packer: directed and random descriptor streams.
// Depends on asp_pkg and aligned_slot_packer; predicts slot placement in-bench.
module testbench
    import asp_pkg::*;
();

    // Bench sizing
    localparam int MAX_GAP       = 16;                       // longest idle draw per item
    localparam int SETTLE_CYCLES = 128 + 5 * MAX_CHUNKS;     // worst split run, plus slack
    localparam int RANDOM_ITEMS  = 85;
    localparam int STALL_CYCLES  = 400;                      // long sink hold-off
    localparam logic [63:0] ALIGN64 = ALIGN;
    localparam logic [63:0] MASK48  = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [1:0]  CMD_SPARE = 2'd3;                // unused role code

    // One packed entry as it leaves the block
    typedef struct packed {
        logic [7:0]  slot;
        logic [1:0]  role;
        logic [31:0] first_row;
        logic [31:0] row_len;
        logic [47:0] footprint;
        t_status     status;
        logic        run_last;
        logic        done;
    } t_slot_entry;

    // DUT ports; every input starts at a known value
    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_we      = 1'b0;
    logic [47:0]   i_cfg_wdata   = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [79:0]   s_axis_tdata  = '0;   // byte_count[47:0], row_count[79:48]
    logic [1:0]    s_axis_tuser  = '0;   // command[1:0]
    logic          s_axis_tlast  = 1'b0; // last_item
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [119:0]  m_axis_tdata;         // slot[7:0], first_row[39:8], row_len[71:40],
                                         // footprint[119:72]
    logic [5:0]    m_axis_tuser;         // role[1:0], status[4:2], manifest_done[5]
    logic          m_axis_tlast;         // run_last

    // Packing state mirrored by the predictor
    logic [47:0]   lim_bytes  = '0;
    logic [63:0]   fill_bytes = '0;
    int unsigned   cur_slot   = 0;
    bit            grp_empty  = 1'b1;
    bit            mf_aborted = 1'b0;

    t_slot_entry   due_slot_entries[$];  // expected results, oldest first

    // Idle control shared by the driver, the sink and the tests
    int unsigned   feed_gap_max    = MAX_GAP;
    int unsigned   sink_gap_max    = MAX_GAP;
    int unsigned   hold_off_cycles = 0;

    // Bookkeeping for the summary
    int unsigned   mismatches       = 0;
    int unsigned   descriptors_sent = 0;
    int unsigned   live_descriptors = 0;   // descriptors not dropped by an abort
    int unsigned   results_seen     = 0;
    int unsigned   limits_used      = 0;

    aligned_slot_packer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] round_to_align(input logic [63:0] x);
        return (x + ALIGN64 - 64'd1) / ALIGN64 * ALIGN64;
    endfunction

    function automatic void clear_packing();
        fill_bytes = '0;
        cur_slot   = 0;
        grp_empty  = 1'b1;
    endfunction

    function automatic void log_entry(input logic [7:0] slot, input logic [1:0] role,
                                      input logic [31:0] first_row,
                                      input logic [31:0] row_len,
                                      input logic [47:0] footprint, input t_status status,
                                      input bit run_last, input bit done);
        t_slot_entry e;
        e.slot      = slot;
        e.role      = role;
        e.first_row = first_row;
        e.row_len   = row_len;
        e.footprint = footprint;
        e.status    = status;
        e.run_last  = run_last;
        e.done      = done;
        due_slot_entries.insert(due_slot_entries.size(), e);
    endfunction

    // Error ends the manifest: one error entry, packing back to empty,
    // and inputs dropped up to the next last_item unless this was it.
    function automatic void abort_manifest(input logic [1:0] role, input t_status code,
                                           input bit last);
        clear_packing();
        mf_aborted = !last;
        log_entry(8'd0, role, 32'd0, 32'd0, 48'd0, code, 1'b1, 1'b1);
    endfunction

    // Next-fit placement; 0 when a new slot would pass MAX_SLOTS or the
    // running total would leave 48 bits.
    function automatic bit fit_chunk(input logic [63:0] fp, output logic [7:0] slot);
        slot = '0;
        if (!grp_empty && lim_bytes != 0 && fill_bytes + fp > {16'd0, lim_bytes}) begin
            if (cur_slot + 1 >= MAX_SLOTS)
                return 1'b0;
            cur_slot++;
            fill_bytes = '0;
        end
        if (fill_bytes + fp > MASK48)
            return 1'b0;
        fill_bytes += fp;
        grp_empty = 1'b0;
        slot = cur_slot[7:0];
        return 1'b1;
    endfunction

    // Expected entries for one accepted descriptor; returns 0 when the
    // descriptor is dropped because the manifest was aborted.
    function automatic bit pack_descriptor(input logic [1:0] cmd, input logic [47:0] bytes,
                                           input logic [31:0] rows, input bit last);
        logic [1:0]  role;
        logic [63:0] lim64, fp, rows64, rb, maxa, rpc, nchunks, start, len, cfp;
        logic [7:0]  slot;
        bit          limited, tail;
        // role code three packs as an extra input
        if (cmd == ROLE_EMB)
            role = ROLE_EMB;
        else if (cmd == ROLE_POSID)
            role = ROLE_POSID;
        else
            role = ROLE_EXTRA;
        lim64   = {16'd0, lim_bytes};
        limited = lim_bytes != 0;
        fp      = round_to_align({16'd0, bytes});
        rows64  = {32'd0, rows};

        if (mf_aborted) begin
            if (last)
                mf_aborted = 1'b0;
            return 1'b0;
        end

        // oversized embedding: split into row chunks
        if (role == ROLE_EMB && limited && fp > lim64) begin
            if (rows == 0) begin
                abort_manifest(role, ST_NOT_SPLIT, last);
                return 1'b1;
            end
            rb = {16'd0, bytes} / rows64;
            if (rb == 0 || round_to_align(rb) > lim64) begin
                abort_manifest(role, ST_ROW_BIG, last);
                return 1'b1;
            end
            maxa = lim64 / ALIGN64 * ALIGN64;
            rpc  = maxa / rb;
            if (rpc < 1)
                rpc = 1;
            nchunks = (rows64 + rpc - 64'd1) / rpc;
            if (nchunks > MAX_CHUNKS) begin
                abort_manifest(role, ST_OVERFLOW, last);
                return 1'b1;
            end
            for (start = 0; start < rows64; start += rpc) begin
                len  = (rows64 - start < rpc) ? rows64 - start : rpc;
                cfp  = round_to_align(len * rb);   // row remainder is dropped
                tail = start + len >= rows64;
                // slots can run out mid-split, after earlier chunks went out
                if (!fit_chunk(cfp, slot)) begin
                    abort_manifest(role, ST_OVERFLOW, last);
                    return 1'b1;
                end
                log_entry(slot, role, start[31:0], len[31:0], cfp[47:0], ST_OK,
                          tail, tail && last);
            end
            if (last)
                clear_packing();
            return 1'b1;
        end

        if (role != ROLE_EMB && limited && fp > lim64) begin
            if (role == ROLE_POSID)
                abort_manifest(role, ST_POSID_BIG, last);
            else
                abort_manifest(role, ST_EXTRA_BIG, last);
            return 1'b1;
        end
        if (fp > MASK48 || !fit_chunk(fp, slot)) begin
            abort_manifest(role, ST_OVERFLOW, last);
            return 1'b1;
        end
        log_entry(slot, role, 32'd0, rows, fp[47:0], ST_OK, 1'b1, last);
        if (last)
            clear_packing();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stream driver, sink and result checker
    // ------------------------------------------------------------------

    // Offer one descriptor, return at the edge where the transaction happened.
    // tvalid stays high so a following call with no gap streams back to back.
    task automatic send_descriptor(input logic [1:0] cmd, input logic [47:0] bytes,
                                   input logic [31:0] rows, input bit last);
        int unsigned gap;
        gap = $urandom_range(feed_gap_max, 0);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rows, bytes};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        descriptors_sent++;
        if (pack_descriptor(cmd, bytes, rows, last))
            live_descriptors++;
    endtask

    // Stop offering, wait for every expected entry, then let a possible
    // dropped descriptor finish in the block.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (due_slot_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_limit(input logic [47:0] value);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_bytes = value;
        limits_used++;
    endtask

    // Result sink: random ready gaps, plus a long hold-off on request.
    initial begin : result_sink
        int unsigned gap, n;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_cycles != 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            gap = $urandom_range(sink_gap_max, 0);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready) && hold_off_cycles == 0);
        end
    end

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Every result transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_slot_entry want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (due_slot_entries.size() == 0) begin
                $error("result with nothing expected: slot %0d status %0d",
                       m_axis_tdata[7:0], m_axis_tuser[4:2]);
                mismatches++;
            end else begin
                want = due_slot_entries.pop_front();
                compare_field("slot_index",    64'(want.slot),      64'(m_axis_tdata[7:0]));
                compare_field("role",          64'(want.role),      64'(m_axis_tuser[1:0]));
                compare_field("first_row",     64'(want.first_row), 64'(m_axis_tdata[39:8]));
                compare_field("row_len",       64'(want.row_len),   64'(m_axis_tdata[71:40]));
                compare_field("footprint",     64'(want.footprint),
                              64'(m_axis_tdata[119:72]));
                compare_field("status",        64'(want.status),    64'(m_axis_tuser[4:2]));
                compare_field("run_last",      64'(want.run_last),  64'(m_axis_tlast));
                compare_field("manifest_done", 64'(want.done),      64'(m_axis_tuser[5]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No limit: zero sizes, all-ones fields, role three, width overflow of
    // one footprint and of the slot total, and drops after an abort.
    task automatic test_unlimited_packing();
        load_limit(48'd0);
        send_descriptor(ROLE_EMB,   48'd0,    32'd0, 1'b0);
        send_descriptor(ROLE_POSID, 48'd1,    32'd5, 1'b0);
        send_descriptor(CMD_SPARE,  48'd4097, 32'hFFFF_FFFF, 1'b1);
        send_descriptor(ROLE_EMB,   48'hFFFF_FFFF_FFFF, 32'd0, 1'b1);  // rounds past 48 bits
        send_descriptor(ROLE_EXTRA, 48'hFFFF_FFFF_F000, 32'd0, 1'b0);
        send_descriptor(ROLE_POSID, 48'd1,    32'd0, 1'b0);  // total overflows, aborts
        send_descriptor(ROLE_EMB,   48'd5,    32'd0, 1'b0);  // dropped
        send_descriptor(ROLE_EXTRA, 48'd5,    32'd0, 1'b1);  // dropped, ends abort
    endtask

    // Limit of three pages plus change: chunking with a row remainder, each
    // size error, zero rows, zero bytes per row, the 64-chunk edge and one past.
    task automatic test_split_and_errors();
        load_limit(48'd12388);
        send_descriptor(ROLE_EMB,   48'd40001,  32'd10, 1'b0);
        send_descriptor(ROLE_POSID, 48'd13000,  32'd1,  1'b1);
        send_descriptor(ROLE_EXTRA, 48'd13000,  32'd1,  1'b1);
        send_descriptor(CMD_SPARE,  48'd13000,  32'd1,  1'b1);
        send_descriptor(ROLE_EMB,   48'd20000,  32'd0,  1'b1);
        send_descriptor(ROLE_EMB,   48'd20000,  32'd30000, 1'b1);
        send_descriptor(ROLE_EMB,   48'd200000, 32'd2,  1'b1);
        send_descriptor(ROLE_EMB,   48'd64 * 48'd12288, 32'd64, 1'b0);
        send_descriptor(ROLE_EMB,   48'd65 * 48'd12288, 32'd65, 1'b1);
    endtask

    // One page per slot: fill all 256 slots, the last split runs out of
    // slots after 63 chunks and aborts; the trailing tlast is dropped.
    task automatic test_slot_exhaustion();
        load_limit(48'(ALIGN));
        send_descriptor(ROLE_EXTRA, 48'(ALIGN), 32'd0, 1'b0);
        repeat (4)
            send_descriptor(ROLE_EMB, 48'd64 * 48'(ALIGN), 32'd64, 1'b0);
        send_descriptor(ROLE_POSID, 48'd1, 32'd0, 1'b1);
    endtask

    // Largest limit: the all-ones embedding splits in two half-range chunks.
    task automatic test_widest_limit();
        load_limit(48'hFFFF_FFFF_FFFF);
        send_descriptor(ROLE_EMB,   48'hFFFF_FFFF_FFFF, 32'd2, 1'b0);
        send_descriptor(ROLE_EXTRA, 48'(ALIGN), 32'd0, 1'b0);
        send_descriptor(ROLE_POSID, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b1);
    endtask

    // Limit of one byte: only empty buffers fit, any row is too big.
    task automatic test_tiny_limit();
        load_limit(48'd1);
        send_descriptor(ROLE_EMB,   48'd0, 32'd0, 1'b0);
        send_descriptor(ROLE_POSID, 48'd0, 32'd0, 1'b0);
        send_descriptor(ROLE_EMB,   48'd5, 32'd1, 1'b1);
    endtask

    // Sink holds off for a long stretch while descriptors keep coming, so
    // the output register fills and s_axis_tready drops.
    task automatic test_output_stall();
        int i;
        load_limit(48'd8 * 48'(ALIGN));
        feed_gap_max = 0;
        hold_off_cycles = STALL_CYCLES;
        for (i = 0; i < 8; i++)
            send_descriptor(2'(i % 4), 48'(3000 * (i + 1)), 32'(i), i == 7);
        feed_gap_max = MAX_GAP;
        settle_block();
    endtask

    // Random manifests sized around the current limit, with some noise
    // descriptors carrying full-range fields and stray tlast.
    task automatic test_random_manifests();
        int unsigned goal, n, k;
        logic [1:0]  cmd;
        logic [63:0] span, scaled;
        logic [47:0] bytes;
        logic [31:0] rows;
        bit          last;
        goal = descriptors_sent + RANDOM_ITEMS;
        while (descriptors_sent < goal) begin
            if ($urandom_range(3, 0) == 0) begin
                case ($urandom_range(3, 0))
                    0: load_limit(48'd0);
                    1: load_limit(48'(ALIGN * $urandom_range(16, 1)
                                      + $urandom_range(ALIGN - 1, 0)));
                    2: load_limit(48'({$urandom, $urandom}));
                    default: load_limit(48'hFFFF_FFFF_FFFF);
                endcase
            end
            // runs with no idling on one or both sides now and then
            feed_gap_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
            sink_gap_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
            n = $urandom_range(6, 1);
            for (k = 0; k < n; k++) begin
                cmd = 2'($urandom_range(3, 0));
                if ($urandom_range(9, 0) == 0) begin
                    bytes = 48'({$urandom, $urandom});
                    rows  = $urandom;
                    last  = 1'($urandom_range(1, 0));
                end else begin
                    span = (lim_bytes == 0) ? 64'd16 * ALIGN64 : {16'd0, lim_bytes};
                    if (cmd == ROLE_EMB)
                        scaled = span * $urandom_range(400, 0) / 100;
                    else
                        scaled = span * $urandom_range(105, 0) / 100;
                    bytes = scaled[47:0];
                    rows  = ($urandom_range(9, 0) == 0) ? 32'd0 : 32'($urandom_range(24, 1));
                    last  = (k == n - 1);
                end
                send_descriptor(cmd, bytes, rows, last);
            end
        end
        feed_gap_max = MAX_GAP;
        sink_gap_max = MAX_GAP;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unlimited_packing();
        test_split_and_errors();
        test_slot_exhaustion();
        test_widest_limit();
        test_tiny_limit();
        test_output_stall();
        test_random_manifests();
        settle_block();

        $display("Sent %0d descriptors (%0d packed, rest dropped after aborts) under %0d limits",
                 descriptors_sent, live_descriptors, limits_used);
        $display("Checked %0d result transactions, %0d field mismatches",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
